/* hw/rtl/id3p_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 parser package
// Shared region codes, error codes, the queue depth, and the queue entry and result types.
// ----------------------------------------------------------------------------
package id3p_pkg;

	localparam logic [2:0] RG_HEADER  = 3'd0;
	localparam logic [2:0] RG_EXT     = 3'd1;
	localparam logic [2:0] RG_FRAME   = 3'd2;
	localparam logic [2:0] RG_PAYLOAD = 3'd3;
	localparam logic [2:0] RG_PAD     = 3'd4;
	localparam logic [2:0] RG_FOOTER  = 3'd5;
	localparam logic [2:0] RG_IDLE    = 3'd6;

	localparam logic [3:0] ER_OK       = 4'd0;
	localparam logic [3:0] ER_MAGIC    = 4'd1;
	localparam logic [3:0] ER_VERSION  = 4'd2;
	localparam logic [3:0] ER_EXTSMALL = 4'd3;
	localparam logic [3:0] ER_FLAGBYTES = 4'd4;
	localparam logic [3:0] ER_UPDATE   = 4'd5;
	localparam logic [3:0] ER_CRC      = 4'd6;
	localparam logic [3:0] ER_RESTR    = 4'd7;
	localparam logic [3:0] ER_EXTSIZE  = 4'd8;
	localparam logic [3:0] ER_IDCHAR   = 4'd9;
	localparam logic [3:0] ER_OVERRUN  = 4'd10;
	localparam logic [3:0] ER_FMAGIC   = 4'd11;
	localparam logic [3:0] ER_FVERSION = 4'd12;

	localparam int QUEUE_DEPTH = 2;

	// One accepted byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} id3p_item_t;

	// One result as it travels from the back to the output stage.
	typedef struct packed {
		logic [2:0]  region;
		logic [7:0]  data;
		logic        fh_valid;
		logic [31:0] fid;
		logic [27:0] fsize;
		logic [15:0] fflags;
		logic [27:0] tsize;
		logic [7:0]  tflags;
		logic [3:0]  err;
		logic        done;
	} id3p_result_t;

endpackage

/* hw/rtl/id3v2_tag_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2.4 tag stream parser
// Byte-serial tag parser: header, extended header, frames, padding, footer.
// ----------------------------------------------------------------------------
// The parser takes one tag byte per transfer and returns exactly one result
// per byte, in order. Bytes enter a short queue, so the input side keeps
// accepting until the queue fills while a result waits; the core handles one
// byte per cycle while out_ready allows, its throughput set by the single
// state update each byte needs. Bytes pass the queue and the result register;
// a steady stream runs at one byte per cycle while out_ready stays high.
// Assert tag_start with the first header byte of each tag; errors are sticky
// and the parser idles (region 6) until the next tag_start.
module id3v2_tag_stream_parser
	import id3p_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        tag_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  region,
	output logic [7:0]  byte_out,
	output logic        frame_header_valid,
	output logic [31:0] frame_id,
	output logic [27:0] frame_size,
	output logic [15:0] frame_flags,
	output logic [27:0] tag_size,
	output logic [7:0]  tag_flags,
	output logic [3:0]  error_code,
	output logic        tag_done
);
	id3p_item_t   q_item;
	logic         q_valid, q_ready;
	id3p_result_t res;

	// Front: queue of accepted transfers.
	id3p_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_item('{data: data_byte, start: tag_start}),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	// Back: the parsing state machine with its registered result.
	id3p_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign region             = res.region;
	assign byte_out           = res.data;
	assign frame_header_valid = res.fh_valid;
	assign frame_id           = res.fid;
	assign frame_size         = res.fsize;
	assign frame_flags        = res.fflags;
	assign tag_size           = res.tsize;
	assign tag_flags          = res.tflags;
	assign error_code         = res.err;
	assign tag_done           = res.done;

endmodule

/* hw/rtl/id3p_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 parser input queue
// Small first-in first-out queue between the front and the parser core.
// ----------------------------------------------------------------------------
module id3p_queue
	import id3p_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  id3p_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output id3p_item_t out_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	id3p_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

/* hw/rtl/id3p_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 parser core
// Walks the tag state machine one byte per cycle while out_ready allows, and registers the result.
// ----------------------------------------------------------------------------
module id3p_core
	import id3p_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  id3p_item_t   in_item,
	output logic         out_valid,
	input  logic         out_ready,
	output id3p_result_t out_res
);
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]  phase_q;
	logic [3:0]  fc_q;
	logic [27:0] bsize_q, bpos_q, esize_q, cursize_q, pleft_q;
	logic [7:0]  hflags_q, eflags_q;
	logic [2:0]  estage_q;
	logic [31:0] curid_q;
	logic [15:0] curflags_q;
	logic [3:0]  err_q;

	logic [2:0]  phase_d;
	logic [3:0]  fc_d;
	logic [27:0] bsize_d, bpos_d, esize_d, cursize_d, pleft_d;
	logic [7:0]  hflags_d, eflags_d;
	logic [2:0]  estage_d;
	logic [31:0] curid_d;
	logic [15:0] curflags_d;
	logic [3:0]  err_d;
	logic        failed, fhv, done;
	logic [2:0]  region;
	logic [7:0]  b;
	logic        take;

	assign in_ready = !out_valid || out_ready;
	assign take = in_valid && in_ready;
	assign b = in_item.data;

	function automatic logic [27:0] spush(input logic [27:0] acc, input logic [7:0] v);
		return {acc[20:0], v[6:0]};
	endfunction

	function automatic logic [2:0] ext_after(input logic [2:0] s, input logic [7:0] f);
		if (s < 3'd1 && f[6]) return 3'd1;
		if (s < 3'd2 && f[5]) return 3'd2;
		if (s < 3'd4 && f[4]) return 3'd4;
		return ST_DONE;
	endfunction

	always_comb begin
		logic [2:0]  nx;
		logic [27:0] es;
		logic        clean;
		logic        adv;
		phase_d = phase_q; fc_d = fc_q; bsize_d = bsize_q; bpos_d = bpos_q;
		esize_d = esize_q; cursize_d = cursize_q; pleft_d = pleft_q;
		hflags_d = hflags_q; eflags_d = eflags_q; estage_d = estage_q;
		curid_d = curid_q; curflags_d = curflags_q; err_d = err_q;
		failed = 1'b0; fhv = 1'b0; done = 1'b0;
		nx = ST_DONE; es = '0; clean = 1'b0; adv = 1'b0;
		if (in_item.start) begin
			phase_d = RG_HEADER; fc_d = '0; bsize_d = '0; bpos_d = '0;
			esize_d = '0; cursize_d = '0; pleft_d = '0; hflags_d = '0;
			eflags_d = '0; estage_d = '0; curid_d = '0; curflags_d = '0;
			err_d = ER_OK;
		end
		region = phase_d;
		case (region)
			RG_HEADER: begin
				case (fc_d)
					4'd0: if (b != 8'h49) failed = 1'b1;
					4'd1: if (b != 8'h44) failed = 1'b1;
					4'd2: if (b != 8'h33) failed = 1'b1;
					default: ;
				endcase
				if (failed) err_d = ER_MAGIC;
				else if ((fc_d == 4'd3 && b != 8'd4) || (fc_d == 4'd4 && b != 8'd0)) begin
					failed = 1'b1; err_d = ER_VERSION;
				end else if (fc_d == 4'd5) hflags_d = b;
				else if (fc_d > 4'd5) bsize_d = spush(bsize_d, b);
				if (!failed) begin
					if (fc_d == 4'd9) begin
						bpos_d = '0; fc_d = '0; estage_d = '0;
						if (bsize_d == '0) begin
							if (hflags_d[6]) begin failed = 1'b1; err_d = ER_OVERRUN; end
							else begin
								fc_d = '0;
								if (hflags_d[4]) phase_d = RG_FOOTER;
								else begin phase_d = RG_IDLE; done = 1'b1; end
							end
						end else phase_d = hflags_d[6] ? RG_EXT : RG_FRAME;
					end else fc_d = fc_d + 4'd1;
				end
			end
			RG_EXT: begin
				case (estage_d)
					3'd0: begin
						if (fc_d < 4'd4) begin
							es = spush(esize_d, b);
							esize_d = es;
							if (fc_d == 4'd3 && es < 28'd6) begin
								failed = 1'b1; err_d = ER_EXTSMALL;
							end else fc_d = fc_d + 4'd1;
						end else if (fc_d == 4'd4) begin
							if (b != 8'd1) begin failed = 1'b1; err_d = ER_FLAGBYTES; end
							else fc_d = 4'd5;
						end else begin
							eflags_d = b; nx = ext_after(3'd0, b); adv = 1'b1;
						end
					end
					3'd1: begin
						if (b != 8'd0) begin failed = 1'b1; err_d = ER_UPDATE; end
						else begin nx = ext_after(3'd1, eflags_d); adv = 1'b1; end
					end
					3'd2: begin
						if (b != 8'd5) begin failed = 1'b1; err_d = ER_CRC; end
						else begin estage_d = 3'd3; fc_d = '0; end
					end
					3'd3: begin
						if (fc_d >= 4'd4) begin nx = ext_after(3'd3, eflags_d); adv = 1'b1; end
						else fc_d = fc_d + 4'd1;
					end
					3'd4: begin
						if (b != 8'd1) begin failed = 1'b1; err_d = ER_RESTR; end
						else begin estage_d = 3'd5; fc_d = '0; end
					end
					default: begin nx = ext_after(3'd5, eflags_d); adv = 1'b1; end
				endcase
				// An advance is pending when a stage finished this byte.
				if (!failed && adv) begin
					estage_d = nx; fc_d = '0;
					if (nx == ST_DONE) begin
						if (bpos_d + 28'd1 != esize_d) begin
							failed = 1'b1; err_d = ER_EXTSIZE;
						end else phase_d = RG_FRAME;
					end
				end
			end
			RG_FRAME: begin
				if (fc_d == 4'd0 && b == 8'd0) phase_d = RG_PAD;
				else begin
					if (fc_d < 4'd4) begin
						if (fc_d == 4'd0) begin
							curid_d = '0; cursize_d = '0; curflags_d = '0;
						end
						curid_d = {curid_d[23:0], b};
						if (!((b inside {[8'h41:8'h5A]}) || (b inside {[8'h30:8'h39]}))) begin
							failed = 1'b1; err_d = ER_IDCHAR;
						end
					end else if (fc_d < 4'd8) cursize_d = spush(cursize_d, b);
					else if (fc_d == 4'd8) curflags_d = {b, 8'd0};
					else curflags_d = {curflags_d[15:8], b};
					if (!failed) begin
						if (fc_d == 4'd9) begin
							fhv = 1'b1; pleft_d = cursize_d; fc_d = '0;
							phase_d = (cursize_d != '0) ? RG_PAYLOAD : RG_FRAME;
						end else fc_d = fc_d + 4'd1;
					end
				end
			end
			RG_PAYLOAD: begin
				pleft_d = pleft_d - 28'd1;
				if (pleft_d == '0) begin phase_d = RG_FRAME; fc_d = '0; end
			end
			RG_FOOTER: begin
				case (fc_d)
					4'd0: if (b != 8'h33) begin failed = 1'b1; err_d = ER_FMAGIC; end
					4'd1: if (b != 8'h44) begin failed = 1'b1; err_d = ER_FMAGIC; end
					4'd2: if (b != 8'h49) begin failed = 1'b1; err_d = ER_FMAGIC; end
					4'd3: if (b != 8'd4) begin failed = 1'b1; err_d = ER_FVERSION; end
					4'd4: if (b != 8'd0) begin failed = 1'b1; err_d = ER_FVERSION; end
					default: ;
				endcase
				if (!failed) begin
					if (fc_d == 4'd9) begin phase_d = RG_IDLE; fc_d = '0; done = 1'b1; end
					else fc_d = fc_d + 4'd1;
				end
			end
			default: ;
		endcase
		if (failed) phase_d = RG_IDLE;
		if (!failed && region >= RG_EXT && region <= RG_PAD) begin
			bpos_d = bpos_d + 28'd1;
			if (bpos_d == bsize_d) begin
				clean = (phase_d == RG_FRAME && fc_d == 4'd0) || phase_d == RG_PAD;
				if (clean) begin
					fc_d = '0;
					if (hflags_d[4]) phase_d = RG_FOOTER;
					else begin phase_d = RG_IDLE; done = 1'b1; end
				end else begin
					failed = 1'b1; err_d = ER_OVERRUN; phase_d = RG_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RG_IDLE; fc_q <= '0; bsize_q <= '0; bpos_q <= '0;
			esize_q <= '0; cursize_q <= '0; pleft_q <= '0; hflags_q <= '0;
			eflags_q <= '0; estage_q <= '0; curid_q <= '0; curflags_q <= '0;
			err_q <= ER_OK; out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d; fc_q <= fc_d; bsize_q <= bsize_d; bpos_q <= bpos_d;
				esize_q <= esize_d; cursize_q <= cursize_d; pleft_q <= pleft_d;
				hflags_q <= hflags_d; eflags_q <= eflags_d; estage_q <= estage_d;
				curid_q <= curid_d; curflags_q <= curflags_d; err_q <= err_d;
			end
			if (take) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_res <= '{region: region, data: b, fh_valid: fhv, fid: curid_d,
				fsize: cursize_d, fflags: curflags_d, tsize: bsize_d,
				tflags: hflags_d, err: err_d, done: done};
		end
	end

endmodule
